// ----- design/grid_bfs_shortest_path_assert.svh -----
// Assertion macros used by the checker file.
`ifndef GRID_BFS_SHORTEST_PATH_ASSERT_SVH
`define GRID_BFS_SHORTEST_PATH_ASSERT_SVH
// Implication checked every clock outside reset.
`define GBSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked every clock outside reset.
`define GBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/gbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gbsp_pkg
// Shared types and constants of the grid shortest-path block.
// ----------------------------------------------------------------------------
`default_nettype none
package gbsp_pkg;
    localparam int COORD_W = 6;
    localparam int LEN_W   = 12;
    localparam int CFG_W   = 7;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Map store size; coordinates are COORD_W bits, so the store is 64 x 64.
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // One queued word between the front and the back.
    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               cell_blocked;
        logic               cell_occupied;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic               ignore_occupied;
        logic               early_done;   // answer known without search
    } cmd_t;
endpackage
`default_nettype wire

// ----- design/gbsp_front.sv -----
// ----------------------------------------------------------------------------
// gbsp_front
// Accepts input words, checks query bounds and holds a short command queue.
// ----------------------------------------------------------------------------
`default_nettype none
module gbsp_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire gbsp_pkg::cmd_t    in_cmd,
    input  wire logic [6:0]        w_eff,
    input  wire logic [6:0]        h_eff,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output gbsp_pkg::cmd_t         q_cmd
);
    import gbsp_pkg::*;

    cmd_t       fifo_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    cmd_t       cls;
    logic       out_of_grid, push;

    assign out_of_grid = ({1'b0, in_cmd.start_x} >= w_eff) || ({1'b0, in_cmd.start_y} >= h_eff)
                      || ({1'b0, in_cmd.target_x} >= w_eff) || ({1'b0, in_cmd.target_y} >= h_eff);

    always_comb
    begin
        cls = in_cmd;
        cls.early_done  = out_of_grid;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

// ----- design/gbsp_back.sv -----
// ----------------------------------------------------------------------------
// gbsp_back
// Applies map writes and runs the breadth-first search over memories.
// ----------------------------------------------------------------------------
`default_nettype none
module gbsp_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire gbsp_pkg::cmd_t  q_cmd,
    input  wire logic [6:0]      w_eff,
    input  wire logic [6:0]      h_eff,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 reachable,
    output logic [11:0]          path_length
);
    import gbsp_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int CNTW  = AW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TCHK, S_TCHK2, S_VCLR, S_POP, S_POP2, S_NB,
        S_NB_RD, S_NB_CHK, S_FQ_RD, S_DONE
    } state_t;

    // Map memory holds {blocked, occupied}; visit memory marks reached cells.
    logic [1:0]       map_mem  [CELLS];
    logic             vis_mem  [CELLS];
    logic [LEN_W-1:0] dist_mem [CELLS];
    logic [AW-1:0]    fq_mem   [CELLS];

    state_t           state_reg;
    logic [CNTW-1:0]  clr_reg, head_reg, tail_reg;
    logic [AW-1:0]    cur_reg, nb_reg;
    logic [XW-1:0]    cx_reg;
    logic [YW-1:0]    cy_reg;
    logic [LEN_W-1:0] d_reg;
    logic [1:0]       k_reg;
    logic             nb_ok_reg;
    logic [1:0]       map_rd_reg;
    logic             vis_rd_reg;
    logic [LEN_W-1:0] dist_rd_reg;
    logic [AW-1:0]    fq_rd_reg;
    logic             out_valid_reg, reach_reg;
    logic [LEN_W-1:0] len_reg;
    logic             out_reach_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic [AW-1:0]    tgt_reg;
    logic             ign_reg;

    logic [AW-1:0]    map_ra, vis_a;
    logic             map_we, vis_we, vis_wd, dist_we, fq_we;
    logic [AW-1:0]    map_wa, dist_wa;
    logic [LEN_W-1:0] dist_wd;
    logic [1:0]       map_wd;
    logic [AW-1:0]    st_idx, tg_idx;
    logic [XW:0]      nx;
    logic [YW:0]      ny;
    logic             nb_in;
    logic             out_free;

    assign st_idx = {q_cmd.start_y[YW-1:0], q_cmd.start_x[XW-1:0]};
    assign tg_idx = {q_cmd.target_y[YW-1:0], q_cmd.target_x[XW-1:0]};
    assign out_free = !out_valid_reg || !out_stall;

    // Neighbor coordinate for direction k: up, right, left, down.
    always_comb
    begin
        nx = {1'b0, cx_reg};
        ny = {1'b0, cy_reg};
        case (k_reg)
            2'd0:    ny = {1'b0, cy_reg} - 1'b1;
            2'd1:    nx = {1'b0, cx_reg} + 1'b1;
            2'd2:    nx = {1'b0, cx_reg} - 1'b1;
            default: ny = {1'b0, cy_reg} + 1'b1;
        endcase
        nb_in = !nx[XW] && !ny[YW] && (7'(nx) < w_eff) && (7'(ny) < h_eff);
    end

    always_comb
    begin
        map_we  = 1'b0;
        map_wa  = {q_cmd.cell_y[YW-1:0], q_cmd.cell_x[XW-1:0]};
        map_wd  = {q_cmd.cell_blocked, q_cmd.cell_occupied};
        map_ra  = nb_reg;
        vis_we  = 1'b0;
        vis_wd  = 1'b1;
        vis_a   = nb_reg;
        dist_we = 1'b0;
        dist_wa = nb_reg;
        dist_wd = d_reg + 1'b1;
        fq_we   = 1'b0;
        q_pop   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                map_we = 1'b1;
                map_wa = clr_reg[AW-1:0];
                map_wd = 2'b00;
                vis_we = 1'b1;
                vis_wd = 1'b0;
                vis_a  = clr_reg[AW-1:0];
            end
            S_IDLE:
            begin
                map_ra = tg_idx;
                if (q_valid && q_cmd.op == OP_WRITE)
                begin
                    // Every cell coordinate lies inside the store.
                    map_we = 1'b1;
                    q_pop  = 1'b1;
                end
            end
            S_VCLR:
            begin
                vis_we = 1'b1;
                vis_wd = (clr_reg[AW-1:0] == cur_reg);
                vis_a  = clr_reg[AW-1:0];
                dist_we = (clr_reg[AW-1:0] == cur_reg);
                dist_wa = cur_reg;
                dist_wd = '0;
            end
            S_NB_CHK:
            begin
                if (nb_ok_reg && !map_rd_reg[1] && (ign_reg || !map_rd_reg[0] || nb_reg == tgt_reg)
                    && !vis_rd_reg)
                begin
                    vis_we  = 1'b1;
                    dist_we = 1'b1;
                    fq_we   = (nb_reg != tgt_reg);
                end
            end
            S_DONE:
            begin
                q_pop = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_we && state_reg == S_CLEAR ? clr_reg[AW-1:0] : map_wa] <= map_wd;
        end
        map_rd_reg <= map_mem[map_ra];
        if (vis_we)
        begin
            vis_mem[vis_a] <= vis_wd;
        end
        vis_rd_reg <= vis_mem[nb_reg];
        if (dist_we)
        begin
            dist_mem[dist_wa] <= dist_wd;
        end
        dist_rd_reg <= dist_mem[cur_reg];
        if (fq_we)
        begin
            fq_mem[tail_reg[AW-1:0]] <= nb_reg;
        end
        fq_rd_reg <= fq_mem[head_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            reach_reg     <= 1'b0;
            len_reg       <= '0;
            out_reach_reg <= 1'b0;
            out_len_reg   <= '0;
            k_reg         <= '0;
            cur_reg       <= '0;
            nb_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            d_reg         <= '0;
            nb_ok_reg     <= 1'b0;
            tgt_reg       <= '0;
            ign_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CNTW'(CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid && q_cmd.op == OP_QUERY)
                    begin
                        tgt_reg <= tg_idx;
                        ign_reg <= q_cmd.ignore_occupied;
                        cur_reg <= st_idx;
                        nb_reg  <= tg_idx;
                        state_reg <= S_TCHK;
                    end
                end
                S_TCHK:
                begin
                    // map read of target in flight
                    state_reg <= S_TCHK2;
                end
                S_TCHK2:
                begin
                    if (q_cmd.early_done || map_rd_reg[1])
                    begin
                        reach_reg <= 1'b0;
                        len_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else if (st_idx == tgt_reg)
                    begin
                        reach_reg <= 1'b1;
                        len_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        clr_reg   <= '0;
                        state_reg <= S_VCLR;
                    end
                end
                S_VCLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CNTW'(CELLS - 1))
                    begin
                        head_reg  <= '0;
                        tail_reg  <= '0;
                        state_reg <= S_POP2;
                    end
                end
                S_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        reach_reg <= 1'b0;
                        len_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_reg   <= fq_rd_reg;
                        head_reg  <= head_reg + 1'b1;
                        state_reg <= S_POP2;
                    end
                end
                S_POP2:
                begin
                    // distance read of cur in flight
                    cx_reg    <= cur_reg[XW-1:0];
                    cy_reg    <= cur_reg[AW-1:XW];
                    k_reg     <= '0;
                    state_reg <= S_NB;
                end
                S_NB:
                begin
                    d_reg     <= dist_rd_reg;
                    nb_ok_reg <= nb_in;
                    nb_reg    <= {ny[YW-1:0], nx[XW-1:0]};
                    state_reg <= S_NB_RD;
                end
                S_NB_RD:
                begin
                    state_reg <= S_NB_CHK;
                end
                S_NB_CHK:
                begin
                    if (nb_ok_reg && !map_rd_reg[1]
                        && (ign_reg || !map_rd_reg[0] || nb_reg == tgt_reg) && !vis_rd_reg)
                    begin
                        if (nb_reg == tgt_reg)
                        begin
                            reach_reg <= 1'b1;
                            len_reg   <= d_reg + 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            tail_reg <= tail_reg + 1'b1;
                        end
                    end
                    if (state_reg == S_NB_CHK && !(nb_ok_reg && !map_rd_reg[1]
                        && (ign_reg || !map_rd_reg[0] || nb_reg == tgt_reg) && !vis_rd_reg
                        && nb_reg == tgt_reg))
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= (k_reg == 2'd3) ? S_FQ_RD : S_NB;
                    end
                end
                S_FQ_RD:
                begin
                    // queue head read in flight, past any entry written last cycle
                    state_reg <= S_POP;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reach_reg <= reach_reg;
                        out_len_reg   <= len_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign reachable   = out_reach_reg;
    assign path_length = out_len_reg;
endmodule
`default_nettype wire

// ----- design/grid_bfs_shortest_path.sv -----
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path
// Grid map store with a four-neighbor breadth-first shortest-path search.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 64x64 map memory clear, one cell a cycle,
// before it carries out any word (input words still queue up to two deep).
// The back end applies a map write in the same cycle that it pops the word.
// A query whose answer is known up front (outside the grid, blocked target,
// start on the target) goes from the target check straight to its result
// with no search. A full search first sweeps the visit marks clear, then
// for each dequeued cell computes, reads and checks each of its four
// neighbors in turn before it reads the next queue head. The memories give
// one read per cycle, which sets this step-by-step pace. Results wait in an
// output register, so the front keeps filling its two-word queue while a
// result is stalled.
`default_nettype none
module grid_bfs_shortest_path
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [5:0]  cell_x,
    input  wire logic [5:0]  cell_y,
    input  wire logic        cell_blocked,
    input  wire logic        cell_occupied,
    input  wire logic [5:0]  start_x,
    input  wire logic [5:0]  start_y,
    input  wire logic [5:0]  target_x,
    input  wire logic [5:0]  target_y,
    input  wire logic        ignore_occupied,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             reachable,
    output logic [11:0]      path_length,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);
    import gbsp_pkg::*;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CFG_W-1:0] w_eff, h_eff;
    cmd_t             in_cmd, q_cmd;
    logic             q_valid, q_pop;

    // Hold the configured size; clip to the store size on use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDX_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    assign w_eff = (32'(width_reg) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (32'(height_reg) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_reg;

    always_comb
    begin
        in_cmd.op              = op;
        in_cmd.cell_x          = cell_x;
        in_cmd.cell_y          = cell_y;
        in_cmd.cell_blocked    = cell_blocked;
        in_cmd.cell_occupied   = cell_occupied;
        in_cmd.start_x         = start_x;
        in_cmd.start_y         = start_y;
        in_cmd.target_x        = target_x;
        in_cmd.target_y        = target_y;
        in_cmd.ignore_occupied = ignore_occupied;
        in_cmd.early_done      = 1'b0;
    end

    gbsp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_cmd   (in_cmd),
        .w_eff    (w_eff),
        .h_eff    (h_eff),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    gbsp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reachable   (reachable),
        .path_length (path_length)
    );
endmodule
`default_nettype wire

// ----- design/gbsp_checker.sv -----
// ----------------------------------------------------------------------------
// gbsp_checker
// Port-level checks of the grid shortest-path block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_bfs_shortest_path_assert.svh"
module gbsp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        reachable,
    input wire logic [11:0] path_length
);
    // An unreachable answer carries a zero length.
    `GBSP_ASSERT_IMP(a_unreach_zero, clk, rst_n, out_valid && !reachable, path_length == 12'd0)
    // A stalled result holds.
    `GBSP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(path_length) && $stable(reachable))
    // No result comes out straight after reset release.
    `GBSP_ASSERT_NEXT(a_reset_quiet, clk, rst_n, $rose(rst_n), !out_valid)
endmodule

bind grid_bfs_shortest_path gbsp_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reachable   (reachable),
    .path_length (path_length)
);
`default_nettype wire

// ----- dv/grid_bfs_shortest_path_tb.sv -----
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path_tb
// Self-checking bench for the grid shortest-path block: a directed table of
// map writes and path queries, then random phases over several grid sizes.
// Every query answer is checked against the table's value or a breadth-first
// search kept in the bench, with randomly idling sender and receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module grid_bfs_shortest_path_tb;
    import gbsp_pkg::*;

    localparam int MAP_W  = 64;
    localparam int MAP_H  = 64;
    localparam int CELL_N = MAP_W * MAP_H;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic             reach;
        logic [LEN_W-1:0] len;
    } answer_t;

    // One row of the directed table. For a map write a/b are the cell, for a
    // query a/b are the start and c/d the target.
    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] d;
        logic               blk;
        logic               occ;
        logic               ign;
        logic               typed;
        logic               e_reach;
        logic [LEN_W-1:0]   e_len;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_blocked;
    logic               cell_occupied;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic               ignore_occupied;
    logic               out_valid;
    logic               out_stall;
    logic               reachable;
    logic [LEN_W-1:0]   path_length;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    grid_bfs_shortest_path dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .cell_blocked   (cell_blocked),
        .cell_occupied  (cell_occupied),
        .start_x        (start_x),
        .start_y        (start_y),
        .target_x       (target_x),
        .target_y       (target_y),
        .ignore_occupied(ignore_occupied),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reachable      (reachable),
        .path_length    (path_length),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Bench copy of the block's state.
    logic [CFG_W-1:0] grid_w_cfg;
    logic [CFG_W-1:0] grid_h_cfg;
    bit               blk_map [CELL_N];
    bit               occ_map [CELL_N];
    bit               seen_map[CELL_N];
    int               step_map[CELL_N];

    answer_t pending_answers[$];
    int      mismatch_cnt;
    int      answer_cnt;
    int      query_cnt;
    int      write_cnt;
    bit      hold_req;   // ask the receiver for one long hold-off
    bit      quiet_tx;   // no sender gaps in this phase

    // 4-unit clock period.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shortest step count by breadth-first search; neighbors in the order
    // up, right, left, down.
    function automatic answer_t path_predict(input logic [COORD_W-1:0] sx,
                                             input logic [COORD_W-1:0] sy,
                                             input logic [COORD_W-1:0] tx,
                                             input logic [COORD_W-1:0] ty,
                                             input logic ign);
        int dx[4] = '{0, 1, -1, 0};
        int dy[4] = '{-1, 0, 0, 1};
        int w, h, tgt, cur, nx, ny, n, hops;
        int frontier[$];
        answer_t ans;
        ans = '0;
        hops = -1;
        w = (grid_w_cfg < MAP_W) ? grid_w_cfg : MAP_W;
        h = (grid_h_cfg < MAP_H) ? grid_h_cfg : MAP_H;
        tgt = ty * MAP_W + tx;
        if (w == 0 || h == 0 || sx >= w || sy >= h || tx >= w || ty >= h)
            return ans;
        if (blk_map[tgt])
            return ans;
        if (sx == tx && sy == ty)
        begin
            ans.reach = 1'b1;
            return ans;
        end
        foreach (seen_map[i]) seen_map[i] = 1'b0;
        cur = sy * MAP_W + sx;
        seen_map[cur] = 1'b1;
        step_map[cur] = 0;
        frontier.push_back(cur);
        while (frontier.size() > 0 && hops < 0)
        begin
            cur = frontier.pop_front();
            for (int k = 0; k < 4 && hops < 0; k++)
            begin
                nx = cur % MAP_W + dx[k];
                ny = cur / MAP_W + dy[k];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                n = ny * MAP_W + nx;
                if (blk_map[n]) continue;
                if (n != tgt && !ign && occ_map[n]) continue;
                if (seen_map[n]) continue;
                seen_map[n] = 1'b1;
                step_map[n] = step_map[cur] + 1;
                if (n == tgt) hops = step_map[n];
                else frontier.push_back(n);
            end
        end
        if (hops >= 0)
        begin
            ans.reach = 1'b1;
            ans.len = (hops > LEN_MAX) ? LEN_MAX : hops[LEN_W-1:0];
        end
        return ans;
    endfunction

    // Offer one word and hold it until accepted, then update the bench
    // state. Call at a rising edge; returns at the accepting edge.
    task automatic issue_word(input logic wop,
                              input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                              input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] d,
                              input logic blk, input logic occ, input logic ign,
                              input logic typed, input answer_t typed_ans);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        gap = (quiet_tx || r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                  : $urandom_range(15, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op              <= wop;
        ignore_occupied <= ign;
        if (wop == OP_WRITE)
        begin
            cell_x <= a; cell_y <= b; cell_blocked <= blk; cell_occupied <= occ;
            start_x <= COORD_W'($urandom); start_y <= COORD_W'($urandom);
            target_x <= COORD_W'($urandom); target_y <= COORD_W'($urandom);
        end
        else
        begin
            start_x <= a; start_y <= b; target_x <= c; target_y <= d;
            cell_x <= COORD_W'($urandom); cell_y <= COORD_W'($urandom);
            cell_blocked <= 1'($urandom); cell_occupied <= 1'($urandom);
        end
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (wop == OP_WRITE)
        begin
            blk_map[b * MAP_W + a] = blk;
            occ_map[b * MAP_W + a] = occ;
            write_cnt++;
        end
        else
        begin
            pending_answers.push_back(typed ? typed_ans : path_predict(a, b, c, d, ign));
            query_cnt++;
        end
    endtask

    // Drop valid and wait for every outstanding answer, then let queued map
    // writes drain before the grid size may change.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we <= 1'b1; cfg_index <= CFG_IDX_WIDTH; cfg_data <= w;
        @(posedge clk);
        grid_w_cfg = w;
        cfg_index <= CFG_IDX_HEIGHT; cfg_data <= h;
        @(posedge clk);
        grid_h_cfg = h;
        cfg_we <= 1'b0;
    endtask

    // Coordinate mostly inside the grid in use, sometimes anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_W-1:0] lim);
        int eff;
        eff = (lim == 0) ? 1 : (lim > MAP_W) ? MAP_W : lim;
        if ($urandom_range(0, 99) < 85) return COORD_W'($urandom_range(0, eff - 1));
        return COORD_W'($urandom_range(0, MAP_W - 1));
    endfunction

    // Receiver: random stalls in bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (20000) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                stall_left = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                     : $urandom_range(20, 80);
                out_stall <= (stall_left > 0);
            end
        end
    end

    // Check each accepted answer against the oldest expectation.
    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && out_valid && !out_stall)
        begin
            answer_cnt++;
            if (pending_answers.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected answer reach=%0d len=%0d", reachable, path_length);
            end
            else
            begin
                exp_ans = pending_answers.pop_front();
                if (reachable !== exp_ans.reach || path_length !== exp_ans.len)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("answer %0d: expected reach=%0d len=%0d, got reach=%0d len=%0d",
                                 answer_cnt, exp_ans.reach, exp_ans.len,
                                 reachable, path_length);
                end
            end
        end
    end

    // Hard limit on the run.
    initial
    begin
        #40000000;
        $display("status: fail");
        $finish;
    end

    localparam answer_t NO_ANS = '0;

    // Directed table: corners of the full 64x64 grid, a blocked target,
    // an occupied target, a start walled in by units, a blocked start and
    // the field extremes.
    dir_row_t dir_rows[] = '{
        '{OP_QUERY, 6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 12'd0},
        '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 12'd126},
        '{OP_QUERY, 6'd63, 6'd0,  6'd0,  6'd63, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 12'd126},
        '{OP_WRITE, 6'd5,  6'd5,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_QUERY, 6'd5,  6'd5,  6'd5,  6'd5,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0},
        '{OP_QUERY, 6'd0,  6'd0,  6'd5,  6'd5,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0},
        '{OP_WRITE, 6'd5,  6'd6,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_QUERY, 6'd5,  6'd7,  6'd5,  6'd6,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 12'd1},
        '{OP_WRITE, 6'd1,  6'd0,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_WRITE, 6'd0,  6'd1,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_QUERY, 6'd0,  6'd0,  6'd2,  6'd0,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0},
        '{OP_QUERY, 6'd0,  6'd0,  6'd2,  6'd0,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 12'd2},
        '{OP_WRITE, 6'd10, 6'd10, 6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_QUERY, 6'd10, 6'd10, 6'd10, 6'd12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_QUERY, 6'd0,  6'd1,  6'd6,  6'd5,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_WRITE, 6'd63, 6'd63, 6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0},
        '{OP_WRITE, 6'd63, 6'd63, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0},
        '{OP_QUERY, 6'd62, 6'd62, 6'd63, 6'd63, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 12'd2}
    };

    // Grid sizes of the random phases: small grids, a zero size and sizes
    // above the store, which clip to 64.
    int phase_w[7] = '{8, 1, 127, 0, 16, 3, 6};
    int phase_h[7] = '{8, 64, 3, 5, 12, 1, 127};

    initial
    begin
        answer_t row_ans;
        logic    is_query;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_WRITE;
        cell_x = '0; cell_y = '0; cell_blocked = 1'b0; cell_occupied = 1'b0;
        start_x = '0; start_y = '0; target_x = '0; target_y = '0;
        ignore_occupied = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_IDX_WIDTH; cfg_data = '0;
        hold_req = 1'b0;
        quiet_tx = 1'b0;
        mismatch_cnt = 0; answer_cnt = 0; query_cnt = 0; write_cnt = 0;
        grid_w_cfg = 7'd64;
        grid_h_cfg = 7'd64;
        foreach (blk_map[i])
        begin
            blk_map[i] = 1'b0;
            occ_map[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the full grid.
        set_grid(7'd64, 7'd64);
        foreach (dir_rows[i])
        begin
            row_ans.reach = dir_rows[i].e_reach;
            row_ans.len = dir_rows[i].e_len;
            issue_word(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
                       dir_rows[i].d, dir_rows[i].blk, dir_rows[i].occ, dir_rows[i].ign,
                       dir_rows[i].typed, row_ans);
        end
        drain_block();

        // Random phases: each resizes the grid while idle, then mixes map
        // writes that build obstacles with queries mostly inside the grid.
        for (int p = 0; p < 7; p++)
        begin
            set_grid(CFG_W'(phase_w[p]), CFG_W'(phase_h[p]));
            quiet_tx = (p == 1);
            if (p == 2) hold_req = 1'b1;
            for (int n = 0; n < 12; n++)
            begin
                is_query = ($urandom_range(0, 99) < 55);
                issue_word(is_query ? OP_QUERY : OP_WRITE,
                           pick_coord(grid_w_cfg), pick_coord(grid_h_cfg),
                           pick_coord(grid_w_cfg), pick_coord(grid_h_cfg),
                           $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 25,
                           1'($urandom_range(0, 1)), 1'b0, NO_ANS);
            end
            drain_block();
        end

        $display("covered %0d map writes and %0d queries over %0d grid sizes",
                 write_cnt, query_cnt, 8);
        $display("checked %0d answers, %0d mismatches", answer_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
